@@ design/mmsh_pkg.sv @@
// Package for the multi-method string hash: method codes and hash constants.
// No dependencies.
package mmsh_pkg;

  typedef enum logic [1:0] {
    METH_FNV1A  = 2'd0,
    METH_FNV1   = 2'd1,
    METH_DJB2   = 2'd2,
    METH_MURMUR = 2'd3
  } method_e;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] DJB_INIT  = 32'd5381;
  localparam logic [31:0] DJB_MUL   = 32'd33;
  localparam logic [31:0] MUR_M     = 32'h5bd1e995;
  localparam int unsigned MUR_R     = 24;
  localparam int unsigned FIN_R1    = 13;
  localparam int unsigned FIN_R2    = 15;

endpackage

@@ design/mmsh_mul.sv @@
// Shared 32x32 multiplier, low 32 bits of the product, registered.
// No dependencies; driven by the sequencer in multi_method_string_hash.
module mmsh_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  logic [31:0] p_q;
  logic [31:0] p_d;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

@@ design/multi_method_string_hash.sv @@
// Multi-method 32-bit string hash (FNV-1a, FNV-1, djb2, MurmurHash2 seed 0).
// Depends on mmsh_pkg and mmsh_mul.
//
// Usage: one string byte per input transfer on the s_axis channel. tdata holds
// the byte (bits 7:0) and the string length (bits 39:8, read on the first
// transfer of a string for the MurmurHash2 seed). tuser flags a valid byte;
// tuser low with tlast high closes a string without a byte (empty string).
// Transfers with neither flag are taken and ignored. The cfg channel writes
// the 2-bit method; write it only while the block is idle.
// All methods share one 32x32 multiplier: an FNV or djb2 byte takes one
// multiply; a MurmurHash2 byte is buffered, and a completed word takes
// three chained multiplies. The closing transfer adds the finish, then the
// hash is loaded into the m_axis output register. s_axis_tready is high
// only while the sequencer is idle. The output register lets the next
// string start while a result waits; a stalled receiver holds the
// sequencer at the final step of the next string until the register
// frees. Reset clears the method to FNV-1a, closes any open string and
// empties the output register.
module multi_method_string_hash
  import mmsh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // data_byte [7:0], total_length [39:8]
  input  logic        s_axis_tuser,  // has_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // hash_value [31:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_ABS  = 11'b000_0000_0010,
    ST_MA   = 11'b000_0000_0100,
    ST_MK1  = 11'b000_0000_1000,
    ST_MK2  = 11'b000_0001_0000,
    ST_MH   = 11'b000_0010_0000,
    ST_FIN  = 11'b000_0100_0000,
    ST_F1   = 11'b000_1000_0000,
    ST_F2   = 11'b001_0000_0000,
    ST_F3   = 11'b010_0000_0000,
    ST_OUT  = 11'b100_0000_0000
  } state_e;

  state_e      state_q, state_d;
  method_e     cfg_meth_q, cfg_meth_d;
  method_e     meth_q, meth_d;
  logic        inside_q, inside_d;
  logic        last_q, last_d;
  logic [7:0]  byte_q, byte_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] wbuf_q, wbuf_d;
  logic [31:0] k_q, k_d;
  logic [1:0]  pend_q, pend_d;
  logic        ovalid_q, ovalid_d;
  logic [31:0] odata_q, odata_d;

  logic        mul_en;
  logic [31:0] mul_a, mul_b, mul_p;
  logic        s_acc;
  logic [31:0] wnew;
  logic [1:0]  pend_inc;
  logic [31:0] init_val;
  state_e      after_abs;

  mmsh_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  assign wnew      = wbuf_q | ({24'd0, byte_q} << {pend_q, 3'b000});
  assign pend_inc  = pend_q + 2'd1;
  assign after_abs = last_q ? ST_FIN : ST_IDLE;

  always_comb begin
    unique case (method_e'(cfg_meth_q))
      METH_MURMUR: init_val = s_axis_tdata[39:8];
      METH_DJB2:   init_val = DJB_INIT;
      default:     init_val = FNV_BASIS;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cfg_meth_d = cfg_meth_q;
    meth_d     = meth_q;
    inside_d   = inside_q;
    last_d     = last_q;
    byte_d     = byte_q;
    acc_d      = acc_q;
    wbuf_d     = wbuf_q;
    k_d        = k_q;
    pend_d     = pend_q;
    ovalid_d   = ovalid_q;
    odata_d    = odata_q;
    mul_en     = 1'b0;
    mul_a      = acc_q;
    mul_b      = MUR_M;

    if (cfg_valid_i && cfg_ready_o) begin
      cfg_meth_d = method_e'(cfg_data_i);
    end
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc && (s_axis_tuser || s_axis_tlast)) begin
          meth_d = cfg_meth_q;
          byte_d = s_axis_tdata[7:0];
          last_d = s_axis_tlast;
          if (!inside_q) begin
            acc_d    = init_val;
            wbuf_d   = '0;
            pend_d   = '0;
            inside_d = 1'b1;
          end
          state_d = s_axis_tuser ? ST_ABS : ST_FIN;
        end
      end
      ST_ABS: begin
        unique case (meth_q)
          METH_FNV1A: begin
            mul_en  = 1'b1;
            mul_a   = acc_q ^ {24'd0, byte_q};
            mul_b   = FNV_PRIME;
            state_d = ST_MA;
          end
          METH_FNV1: begin
            mul_en  = 1'b1;
            mul_b   = FNV_PRIME;
            state_d = ST_MA;
          end
          METH_DJB2: begin
            mul_en  = 1'b1;
            mul_b   = DJB_MUL;
            state_d = ST_MA;
          end
          default: begin
            pend_d = pend_inc;
            if (pend_inc == 2'd0) begin
              mul_en  = 1'b1;
              mul_a   = wnew;
              state_d = ST_MK1;
            end else begin
              wbuf_d  = wnew;
              state_d = after_abs;
            end
          end
        endcase
      end
      ST_MA: begin
        unique case (meth_q)
          METH_FNV1:  acc_d = mul_p ^ {24'd0, byte_q};
          METH_DJB2:  acc_d = mul_p + {24'd0, byte_q};
          default:    acc_d = mul_p;
        endcase
        state_d = after_abs;
      end
      ST_MK1: begin
        mul_en  = 1'b1;
        mul_a   = mul_p ^ (mul_p >> MUR_R);
        state_d = ST_MK2;
      end
      ST_MK2: begin
        k_d     = mul_p;
        mul_en  = 1'b1;
        state_d = ST_MH;
      end
      ST_MH: begin
        acc_d   = mul_p ^ k_q;
        wbuf_d  = '0;
        state_d = after_abs;
      end
      ST_FIN: begin
        if (meth_q != METH_MURMUR) begin
          state_d = ST_OUT;
        end else if (pend_q != 2'd0) begin
          mul_en  = 1'b1;
          mul_a   = acc_q ^ wbuf_q;
          state_d = ST_F1;
        end else begin
          state_d = ST_F2;
        end
      end
      ST_F1: begin
        acc_d   = mul_p;
        state_d = ST_F2;
      end
      ST_F2: begin
        mul_en  = 1'b1;
        mul_a   = acc_q ^ (acc_q >> FIN_R1);
        state_d = ST_F3;
      end
      ST_F3: begin
        acc_d   = mul_p ^ (mul_p >> FIN_R2);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = acc_q;
          inside_d = 1'b0;
          wbuf_d   = '0;
          pend_d   = '0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cfg_meth_q <= METH_FNV1A;
      inside_q   <= 1'b0;
      pend_q     <= '0;
      wbuf_q     <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      cfg_meth_q <= cfg_meth_d;
      inside_q   <= inside_d;
      pend_q     <= pend_d;
      wbuf_q     <= wbuf_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meth_q  <= meth_d;
    last_q  <= last_d;
    byte_q  <= byte_d;
    acc_q   <= acc_d;
    k_q     <= k_d;
    odata_q <= odata_d;
  end

endmodule

@@ tb/sv/mmsh_checker.sv @@
// Checker for multi_method_string_hash: watches the cfg, s_axis and m_axis channels,
// keeps its own hash state per string and compares every m_axis transfer.
// Depends on mmsh_pkg.
module mmsh_checker
  import mmsh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              s_ready_i,
  input  logic [39:0]       s_data_i,   // data_byte [7:0], total_length [39:8]
  input  logic              s_user_i,   // has_byte
  input  logic              s_last_i,
  input  logic              m_valid_i,
  input  logic              m_ready_i,
  input  logic [31:0]       m_data_i,   // hash_value [31:0]
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       due_count_o
);

  method_e     method_q;
  logic [31:0] acc_q;
  logic [31:0] word_q;
  logic [1:0]  fill_q;
  logic        open_q;
  logic [31:0] hash_due[$];
  int unsigned fails;

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [31:0] h;
    logic [31:0] k;
    logic [31:0] byte_w;
    method_e     sel;
    if (!rst_ni) begin
      method_q = METH_FNV1A;
      acc_q    = '0;
      word_q   = '0;
      fill_q   = '0;
      open_q   = 1'b0;
      fails    = 0;
      hash_due.delete();
      fail_count_o <= 0;
      due_count_o  <= 0;
    end else begin
      // a result leaves only after its closing transfer has been taken
      if (m_valid_i && m_ready_i) begin
        if (hash_due.size() == 0) begin
          $display("%0t: hash %h with none expected", $time, m_data_i);
          fails++;
        end else begin
          h = hash_due.pop_front();
          if (m_data_i !== h) begin
            $display("%0t: hash mismatch: expected %h, actual %h", $time, h, m_data_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        method_q = method_e'(cfg_data_i);
      end
      if (s_valid_i && s_ready_i && (s_user_i || s_last_i)) begin
        sel    = method_q;
        byte_w = {24'd0, s_data_i[7:0]};
        if (!open_q) begin
          case (sel)
            METH_MURMUR: acc_q = s_data_i[39:8];
            METH_DJB2:   acc_q = DJB_INIT;
            default:     acc_q = FNV_BASIS;
          endcase
          word_q = '0;
          fill_q = '0;
          open_q = 1'b1;
        end
        h = acc_q;
        if (s_user_i) begin
          case (sel)
            METH_FNV1A: h = (h ^ byte_w) * FNV_PRIME;
            METH_FNV1:  h = (h * FNV_PRIME) ^ byte_w;
            METH_DJB2:  h = h * DJB_MUL + byte_w;
            default: begin
              word_q = word_q | (byte_w << (8 * fill_q));
              fill_q = fill_q + 2'd1;
              if (fill_q == 2'd0) begin
                k      = word_q * MUR_M;
                k      = k ^ (k >> MUR_R);
                k      = k * MUR_M;
                h      = (h * MUR_M) ^ k;
                word_q = '0;
              end
            end
          endcase
          acc_q = h;
        end
        if (s_last_i) begin
          if (sel == METH_MURMUR) begin
            if (fill_q != 2'd0) begin
              h = (h ^ word_q) * MUR_M;
            end
            h = h ^ (h >> FIN_R1);
            h = h * MUR_M;
            h = h ^ (h >> FIN_R2);
          end
          hash_due.push_back(h);
          open_q = 1'b0;
          word_q = '0;
          fill_q = '0;
        end
      end
      fail_count_o <= fails;
      due_count_o  <= hash_due.size();
    end
  end

endmodule

@@ tb/sv/tb_multi_method_string_hash.sv @@
// Top of the multi_method_string_hash testbench: clock, reset, method writes,
// string stimulus with random idling on both sides, and the verdict.
// Depends on mmsh_pkg, multi_method_string_hash and mmsh_checker.
module tb_multi_method_string_hash
  import mmsh_pkg::*;
;

  localparam int unsigned ITEM_TARGET   = 850;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned CALM_ITEMS    = 120;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // data_byte [7:0], total_length [39:8]
  logic        s_axis_tuser;   // has_byte
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // hash_value [31:0]
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned items_sent;
  bit          jitter_on;
  bit          sink_hold;

  multi_method_string_hash uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  mmsh_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .s_last_i     (s_axis_tlast),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin : sink
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (jitter_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [7:0] data_byte, input bit has_byte,
                           input bit last, input logic [31:0] total_len);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {total_len, data_byte};
    s_axis_tuser  <= has_byte;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (has_byte || last) items_sent++;
    if (jitter_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // wait for every hash, then let any ignored transfer drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_method(input method_e sel);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= sel;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_string(input int unsigned len);
    logic [31:0] seed_len;
    bit          close_apart;
    seed_len    = ($urandom_range(0, 7) == 0) ? $urandom : len;
    close_apart = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, $urandom);
      end
      send_item(8'($urandom_range(0, 255)), 1'b1, !close_apart && (i == len - 1),
                (i == 0) ? seed_len : $urandom);
    end
    if (close_apart) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1,
                (len == 0) ? seed_len : $urandom);
    end
  endtask

  initial begin : stimulus
    int unsigned rand_goal;
    int unsigned phase_end;
    int unsigned len;
    method_e     sel;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    items_sent    = 0;
    jitter_on     = 1'b1;
    sink_hold     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // FNV-1a out of reset: empty string, ignored transfer, byte extremes
    send_item(8'h00, 1'b0, 1'b1, 32'd0);
    send_item(8'hFF, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_item(8'h00, 1'b1, 1'b0, 32'd2);
    send_item(8'hFF, 1'b1, 1'b1, 32'd0);
    settle();
    write_method(METH_FNV1);
    send_item(8'hFF, 1'b1, 1'b0, 32'd1);
    send_item(8'h00, 1'b0, 1'b1, 32'd0);
    settle();
    write_method(METH_DJB2);
    send_item(8'h00, 1'b1, 1'b1, 32'd1);
    send_item(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    settle();
    write_method(METH_MURMUR);
    send_item(8'h00, 1'b0, 1'b1, 32'd0);
    // one full word, seed length far off the real one
    for (int i = 0; i < 4; i++) send_item(8'hFF, 1'b1, i == 3, (i == 0) ? 32'hFFFF_FFFF : 32'd0);
    // word plus a one-byte tail
    for (int i = 0; i < 5; i++) send_item(8'($urandom_range(0, 255)), 1'b1, i == 4, 32'd5);
    // three-byte tail closed without a byte
    for (int i = 0; i < 3; i++) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 32'd3);
    send_item(8'h00, 1'b0, 1'b1, 32'd0);

    rand_goal = items_sent + ITEM_TARGET;
    for (int p = 0; items_sent < rand_goal; p++) begin
      settle();
      case (p)
        0:       sel = METH_MURMUR;
        1:       sel = METH_FNV1A;
        2:       sel = METH_FNV1;
        3:       sel = METH_DJB2;
        default: sel = method_e'($urandom_range(0, 3));
      endcase
      write_method(sel);
      if (p == 2) sink_hold = 1'b1;
      if (items_sent + CALM_ITEMS >= rand_goal) jitter_on = 1'b0;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < rand_goal) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
        send_string(len);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ multi_method_string_hash.f @@
design/mmsh_pkg.sv
design/mmsh_mul.sv
design/multi_method_string_hash.sv
tb/sv/mmsh_checker.sv
tb/sv/tb_multi_method_string_hash.sv
